FILE: sv/gda_pkg.sv
// Shared constants and calendar helpers for the Gregorian date adder.
// Used by gregorian_date_add_days; depends on nothing else.
`timescale 1ns / 1ps

package gda_pkg;

    // Field widths fixed by the interface.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 20;

    // Working widths: a day total stays below 512, a year remainder below 400.
    localparam int DSUM_W  = 9;

    // Calendar constants.
    localparam logic [YEAR_W-1:0]  YEAR_MAX      = 14'd9999;
    localparam logic [YEAR_W-1:0]  GREG_CYCLE    = 14'd400;
    localparam logic [YEAR_W-1:0]  REM_LAST      = 14'd399;
    localparam logic [YEAR_W-1:0]  CENTURY_1     = 14'd100;
    localparam logic [YEAR_W-1:0]  CENTURY_2     = 14'd200;
    localparam logic [YEAR_W-1:0]  CENTURY_3     = 14'd300;
    localparam logic [COUNT_W-1:0] LEAP_YEAR_LEN = 20'd366;
    localparam logic [COUNT_W-1:0] YEAR_LEN      = 20'd365;
    localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;

    // Leap-year test from the low year bits and the year modulo 400.
    function automatic logic is_leap(input logic [1:0] year_low,
                                     input logic [YEAR_W-1:0] year_rem);
        logic century;
        century = (year_rem == CENTURY_1) || (year_rem == CENTURY_2)
               || (year_rem == CENTURY_3);
        return (year_low == 2'b00) && !century;
    endfunction

    // Days in a month; zero for a month code outside January to December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

FILE: sv/gregorian_date_add_days.sv
// Gregorian date adder: top level with its sequencer and shared add/subtract unit.
// Depends on gda_pkg for calendar constants and the month-length function.
`timescale 1ns / 1ps

// The block takes one word holding a date and a day count and returns
// one word with the date that many days on, using the full Gregorian leap-year rule. An
// invalid starting date raises input_invalid and is returned unchanged. Work is done by a
// single 20-bit add/subtract unit stepped by a small sequencer, so in_ready is low while a
// word is in progress. The time from one accepted word to the next grows with the start year,
// the number of whole years stepped over and the month steps at the end (at most 11), is
// governed by the whole-year subtraction loop, and includes any wait for the output register
// to be taken.
// A finished result sits in an output register, so the next word can be accepted while
// the previous result still waits to be taken.
module gregorian_date_add_days (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gda_pkg::DAY_W-1:0]   start_day,
    input  logic [gda_pkg::MONTH_W-1:0] start_month,
    input  logic [gda_pkg::YEAR_W-1:0]  start_year,
    input  logic [gda_pkg::COUNT_W-1:0] add_days,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gda_pkg::DAY_W-1:0]   result_day,
    output logic [gda_pkg::MONTH_W-1:0] result_month,
    output logic [gda_pkg::YEAR_W-1:0]  result_year,
    output logic                        input_invalid
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_CHECK,
        ST_SUMLEFT,
        ST_DECIDE,
        ST_YEARS,
        ST_ADD,
        ST_ROLL,
        ST_FINISH
    } state_t;

    state_t                        state_reg;
    logic [gda_pkg::DSUM_W-1:0]    day_reg;
    logic [gda_pkg::MONTH_W-1:0]   month_reg;
    logic [gda_pkg::YEAR_W-1:0]    year_reg;
    logic [gda_pkg::YEAR_W-1:0]    rem_reg;
    logic [gda_pkg::COUNT_W-1:0]   count_reg;
    logic [gda_pkg::DSUM_W-1:0]    left_reg;
    logic [gda_pkg::MONTH_W-1:0]   idx_reg;
    logic                          bad_reg;
    logic                          out_valid_reg;
    logic [gda_pkg::DAY_W-1:0]     res_day_reg;
    logic [gda_pkg::MONTH_W-1:0]   res_month_reg;
    logic [gda_pkg::YEAR_W-1:0]    res_year_reg;
    logic                          res_bad_reg;

    logic                          leap;
    logic [gda_pkg::DAY_W-1:0]     cur_len;
    logic [gda_pkg::DAY_W-1:0]     idx_len;
    logic                          year_bad;
    logic                          date_bad;
    logic [gda_pkg::YEAR_W-1:0]    rem_inc;
    logic [gda_pkg::COUNT_W-1:0]   alu_a;
    logic [gda_pkg::COUNT_W-1:0]   alu_b;
    logic                          alu_sub;
    logic [gda_pkg::COUNT_W:0]     alu_res;
    logic                          alu_carry;
    logic                          alu_zero;

    // Calendar facts about the date held in the working registers.
    assign leap     = gda_pkg::is_leap(year_reg[1:0], rem_reg);
    assign cur_len  = gda_pkg::month_len(month_reg, leap);
    assign idx_len  = gda_pkg::month_len(idx_reg, leap);
    assign year_bad = (year_reg == '0) || (year_reg > gda_pkg::YEAR_MAX);
    assign date_bad = (cur_len == '0) || (day_reg == '0)
                   || (day_reg > gda_pkg::DSUM_W'(cur_len)) || year_bad;
    assign rem_inc  = (rem_reg == gda_pkg::REM_LAST) ? '0 : rem_reg + 1'b1;

    // Operand selection for the shared add/subtract unit.
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        case (state_reg)
            ST_MOD:
            begin
                alu_a = gda_pkg::COUNT_W'(rem_reg);
                alu_b = gda_pkg::COUNT_W'(gda_pkg::GREG_CYCLE);
            end
            ST_CHECK:
            begin
                alu_a = gda_pkg::COUNT_W'(cur_len);
                alu_b = gda_pkg::COUNT_W'(day_reg);
            end
            ST_SUMLEFT:
            begin
                alu_a   = gda_pkg::COUNT_W'(left_reg);
                alu_b   = gda_pkg::COUNT_W'(idx_len);
                alu_sub = 1'b0;
            end
            ST_DECIDE:
            begin
                alu_a = count_reg;
                alu_b = gda_pkg::COUNT_W'(left_reg) + 1'b1;
            end
            ST_YEARS:
            begin
                alu_a = count_reg;
                alu_b = leap ? gda_pkg::LEAP_YEAR_LEN : gda_pkg::YEAR_LEN;
            end
            ST_ADD:
            begin
                alu_a   = gda_pkg::COUNT_W'(day_reg);
                alu_b   = count_reg;
                alu_sub = 1'b0;
            end
            ST_ROLL:
            begin
                alu_a = gda_pkg::COUNT_W'(day_reg);
                alu_b = gda_pkg::COUNT_W'(cur_len);
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b1;
            end
        endcase
    end

    // The unit itself: a plus b, or a minus b with carry set when a is at least b.
    assign alu_res   = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b}
                     + (gda_pkg::COUNT_W+1)'(alu_sub);
    assign alu_carry = alu_res[gda_pkg::COUNT_W];
    assign alu_zero  = (alu_res[gda_pkg::COUNT_W-1:0] == '0);

    // Sequencer, working registers and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            day_reg       <= '0;
            month_reg     <= '0;
            year_reg      <= '0;
            rem_reg       <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            res_day_reg   <= '0;
            res_month_reg <= '0;
            res_year_reg  <= '0;
            res_bad_reg   <= 1'b0;
        end
        else
        begin
            // A taken result frees the output register unless a new one replaces it.
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        day_reg   <= gda_pkg::DSUM_W'(start_day);
                        month_reg <= start_month;
                        year_reg  <= start_year;
                        rem_reg   <= start_year;
                        count_reg <= add_days;
                        state_reg <= ST_MOD;
                    end
                end
                // Reduce the year modulo 400 by repeated subtraction.
                ST_MOD:
                begin
                    if (!year_bad && alu_carry)
                    begin
                        rem_reg <= alu_res[gda_pkg::YEAR_W-1:0];
                    end
                    else
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                // Validate the date and start the days-left total.
                ST_CHECK:
                begin
                    bad_reg <= date_bad;
                    if (date_bad)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        left_reg  <= alu_res[gda_pkg::DSUM_W-1:0];
                        idx_reg   <= month_reg + 1'b1;
                        state_reg <= ST_SUMLEFT;
                    end
                end
                // Add the lengths of the remaining months of the year.
                ST_SUMLEFT:
                begin
                    if (idx_reg > gda_pkg::MONTH_DEC)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                    else
                    begin
                        left_reg <= alu_res[gda_pkg::DSUM_W-1:0];
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                // Either stay in this year or move to 1 January of the next.
                ST_DECIDE:
                begin
                    if (alu_carry)
                    begin
                        count_reg <= alu_res[gda_pkg::COUNT_W-1:0];
                        day_reg   <= gda_pkg::DSUM_W'(1);
                        month_reg <= gda_pkg::MONTH_JAN;
                        year_reg  <= year_reg + 1'b1;
                        rem_reg   <= rem_inc;
                        state_reg <= ST_YEARS;
                    end
                    else
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                // Step over whole years.
                ST_YEARS:
                begin
                    if (alu_carry)
                    begin
                        count_reg <= alu_res[gda_pkg::COUNT_W-1:0];
                        year_reg  <= year_reg + 1'b1;
                        rem_reg   <= rem_inc;
                    end
                    else
                    begin
                        state_reg <= ST_ADD;
                    end
                end
                // Fold the remaining count into the day of month.
                ST_ADD:
                begin
                    day_reg   <= alu_res[gda_pkg::DSUM_W-1:0];
                    state_reg <= ST_ROLL;
                end
                // Carry day overflow into following months.
                ST_ROLL:
                begin
                    if (alu_carry && !alu_zero)
                    begin
                        day_reg <= alu_res[gda_pkg::DSUM_W-1:0];
                        if (month_reg == gda_pkg::MONTH_DEC)
                        begin
                            month_reg <= gda_pkg::MONTH_JAN;
                            year_reg  <= year_reg + 1'b1;
                            rem_reg   <= rem_inc;
                        end
                        else
                        begin
                            month_reg <= month_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                // Hand the word over once the output register is free.
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        res_day_reg   <= day_reg[gda_pkg::DAY_W-1:0];
                        res_month_reg <= month_reg;
                        res_year_reg  <= year_reg;
                        res_bad_reg   <= bad_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign result_day    = res_day_reg;
    assign result_month  = res_month_reg;
    assign result_year   = res_year_reg;
    assign input_invalid = res_bad_reg;

    // A valid result always names a real month and a non-zero day.
    a_result_sane : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !input_invalid) |->
            (result_month >= gda_pkg::MONTH_JAN) && (result_month <= gda_pkg::MONTH_DEC)
            && (result_day != '0))
        else $error("result date out of range");

    // The year remainder is below 400 while whole years are stepped and months are rolled.
    a_rem_reduced : assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_YEARS) || (state_reg == ST_ROLL)) |->
            (rem_reg < gda_pkg::GREG_CYCLE))
        else $error("year remainder not reduced");

    // Rolling through months never reaches day zero.
    a_roll_day : assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROLL) |-> (day_reg != '0))
        else $error("day reached zero while rolling months");

endmodule
